// ----- rtl/monotonic_time_from_wall_clock_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for monotonic_time_from_wall_clock
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MONOTONIC_TIME_FROM_WALL_CLOCK_MACROS_SVH
`define MONOTONIC_TIME_FROM_WALL_CLOCK_MACROS_SVH

// Property that must hold at every clock edge.
`define MTWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define MTWC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtwc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtwc_pkg
// Types and constants for the monotonic time from wall clock block.
// ----------------------------------------------------------------------------
package mtwc_pkg;

  localparam int unsigned SecBitsDefault = 32;
  localparam int unsigned SecW           = 32;
  localparam int unsigned UsecW          = 20;
  localparam int unsigned OpW            = 2;
  localparam int unsigned TdataW         = 56;
  localparam int unsigned PadW           = TdataW - SecW - UsecW;

  localparam logic [UsecW-1:0] UsecPerSec = 20'd1000000;
  localparam logic [UsecW-1:0] UsecMax    = 20'd999999;

  typedef enum logic [OpW-1:0] {
    OpRealtime = 2'd0,
    OpMonoRel  = 2'd1,
    OpStable   = 2'd2,
    OpBadClock = 2'd3
  } op_e;

endpackage

// ----- rtl/monotonic_time_from_wall_clock.sv -----
// ----------------------------------------------------------------------------
// monotonic_time_from_wall_clock
// Monotonic relative time and stabilized realtime from wall-clock samples.
// ----------------------------------------------------------------------------
// Takes one word per cycle with no bubbles while the output is not stalled, and
// returns one word for each. The word is captured in an input register, then
// one pass of compare and add/subtract logic updates the stored state and loads
// the result register. That same pass closes the state update (previous sample,
// relative time, base), which sets the one-word-per-cycle rate.
// tuser selects the clock: 0 realtime, 1 monotonic relative, 2 stabilized
// realtime, 3 invalid (result zero, m_axis_tuser high). Seconds are kept
// modulo 2^SEC_BITS; microseconds above 999999 are clamped.
`include "monotonic_time_from_wall_clock_macros.svh"

module monotonic_time_from_wall_clock #(
  parameter int unsigned SEC_BITS = mtwc_pkg::SecBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] wall_sec, [51:32] wall_usec, [55:52] zero
  input  logic [mtwc_pkg::TdataW-1:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [mtwc_pkg::OpW-1:0]    s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [31:0] time_sec, [51:32] time_usec, [55:52] zero
  output logic [mtwc_pkg::TdataW-1:0] m_axis_tdata,
  // [0] bad_clock
  output logic                        m_axis_tuser
);
  import mtwc_pkg::*;

  localparam int unsigned SumW = UsecW + 1;

  // input register
  logic                s1_valid_q;
  op_e                 s1_op_q;
  logic [SecW-1:0]     s1_sec_q;
  logic [UsecW-1:0]    s1_usec_q;

  // block state
  logic [SEC_BITS-1:0] prev_sec_q, prev_sec_d;
  logic [UsecW-1:0]    prev_usec_q, prev_usec_d;
  logic [SEC_BITS-1:0] mono_sec_q, mono_sec_d;
  logic [UsecW-1:0]    mono_usec_q, mono_usec_d;
  logic [SEC_BITS-1:0] base_sec_q, base_sec_d;
  logic [UsecW-1:0]    base_usec_q, base_usec_d;
  logic                started_q, started_d;

  // result register
  logic                out_valid_q;
  logic [SecW-1:0]     out_sec_q, out_sec_d;
  logic [UsecW-1:0]    out_usec_q, out_usec_d;
  logic                out_bad_q, out_bad_d;

  logic                out_load;

  logic [SEC_BITS-1:0] ws, ps, ds, adv_sec, stab_sec, res_sec;
  logic [UsecW-1:0]    wu, pu, du, adv_usec, stab_usec, res_usec;
  logic [SumW-1:0]     adv_sum, stab_sum;
  logic                usec_lt, back, adv_carry, stab_carry;

  assign out_load      = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op_q   <= op_e'(s_axis_tuser);
      s1_sec_q  <= s_axis_tdata[SecW-1:0];
      s1_usec_q <= s_axis_tdata[SecW+UsecW-1:SecW];
    end
  end

  // sample, with the first sample standing in for the previous one
  always_comb begin
    ws = SEC_BITS'(s1_sec_q);
    wu = (s1_usec_q > UsecMax) ? UsecMax : s1_usec_q;
    ps = started_q ? prev_sec_q : ws;
    pu = started_q ? prev_usec_q : wu;
    usec_lt = wu < pu;
    back    = (ws < ps) || ((ws == ps) && usec_lt);
    du = usec_lt ? UsecW'(SumW'(wu) + SumW'(UsecPerSec) - SumW'(pu)) : (wu - pu);
    ds = ws - ps - SEC_BITS'(usec_lt);

    adv_sum   = SumW'(mono_usec_q) + SumW'(du);
    adv_carry = adv_sum >= SumW'(UsecPerSec);
    adv_usec  = adv_carry ? UsecW'(adv_sum - SumW'(UsecPerSec)) : UsecW'(adv_sum);
    adv_sec   = mono_sec_q + ds + SEC_BITS'(adv_carry);

    stab_sum   = SumW'(base_usec_q) + SumW'(mono_usec_q);
    stab_carry = stab_sum >= SumW'(UsecPerSec);
    stab_usec  = stab_carry ? UsecW'(stab_sum - SumW'(UsecPerSec)) : UsecW'(stab_sum);
    stab_sec   = base_sec_q + mono_sec_q + SEC_BITS'(stab_carry);
  end

  always_comb begin
    prev_sec_d  = prev_sec_q;
    prev_usec_d = prev_usec_q;
    mono_sec_d  = mono_sec_q;
    mono_usec_d = mono_usec_q;
    base_sec_d  = base_sec_q;
    base_usec_d = base_usec_q;
    started_d   = started_q;
    res_sec     = '0;
    res_usec    = '0;
    out_bad_d   = 1'b0;
    unique case (s1_op_q)
      OpRealtime: begin
        if (!started_q) begin
          base_sec_d  = ws;
          base_usec_d = wu;
          prev_sec_d  = ws;
          prev_usec_d = wu;
          started_d   = 1'b1;
        end
        res_sec  = ws;
        res_usec = wu;
      end
      OpMonoRel: begin
        if (!started_q) begin
          base_sec_d  = ws;
          base_usec_d = wu;
          started_d   = 1'b1;
        end
        if (back) begin
          mono_sec_d  = mono_sec_q + SEC_BITS'(1);
          mono_usec_d = '0;
        end else begin
          mono_sec_d  = adv_sec;
          mono_usec_d = adv_usec;
        end
        prev_sec_d  = ws;
        prev_usec_d = wu;
        res_sec     = mono_sec_d;
        res_usec    = mono_usec_d;
      end
      OpStable: begin
        res_sec  = stab_sec;
        res_usec = stab_usec;
      end
      OpBadClock: begin
        out_bad_d = 1'b1;
      end
      default: begin
        out_bad_d = 1'b1;
      end
    endcase
    out_sec_d  = SecW'(res_sec);
    out_usec_d = res_usec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sec_q  <= '0;
      prev_usec_q <= '0;
      mono_sec_q  <= '0;
      mono_usec_q <= '0;
      base_sec_q  <= '0;
      base_usec_q <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        prev_sec_q  <= prev_sec_d;
        prev_usec_q <= prev_usec_d;
        mono_sec_q  <= mono_sec_d;
        mono_usec_q <= mono_usec_d;
        base_sec_q  <= base_sec_d;
        base_usec_q <= base_usec_d;
        started_q   <= started_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sec_q  <= out_sec_d;
      out_usec_q <= out_usec_d;
      out_bad_q  <= out_bad_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PadW'(0), out_usec_q, out_sec_q};
  assign m_axis_tuser  = out_bad_q;

  `MTWC_ASSERT_IMPL(a_bad_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "bad clock word not zero")
  `MTWC_ASSERT_IMPL(a_usec_range, m_axis_tvalid, out_usec_q <= UsecMax, "usec out of range")
  `MTWC_ASSERT(a_started_sticks, !$fell(started_q), "started flag cleared")
  `MTWC_ASSERT_NEXT(a_stall_holds_s1, s1_valid_q && out_valid_q && !m_axis_tready, s1_valid_q, "input word lost under stall")

endmodule
